### rtl/rli_pkg.sv
// Shared types and constants for the range list intersection block.
package rli_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int BOUND_WIDTH = 16;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int ENTRY_W = 2 * BOUND_WIDTH;

  typedef enum logic [1:0] {
    ACT_LOAD  = 2'd0,
    ACT_FIRST = 2'd1,
    ACT_END   = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_WAIT,
    ST_FLUSH,
    ST_STATUS
  } state_e;

endpackage

### rtl/rli_ram.sv
// Generic single-write, single-read RAM with registered read data.
module rli_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                     clk_i,
  input  logic                                     we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                         wdata_i,
  input  logic                                     re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

### rtl/range_list_intersect.sv
// Top level of the range list intersection block.
// Usage: a request is taken when start_i is high and busy_o is low. A load
// request or a first-list range that extends the pending range leaves the
// block idle, as does one when nothing is pending or the table is empty. A
// first-list range that flushes the pending range against the stored ranges
// keeps busy_o high through the scan, wait and flush states: the table is
// read one entry a cycle from its RAM, each entry passing through one shared
// max/min/compare unit. An end request first flushes a pending range in the
// same way if the table is not empty, then gives the status result. Results
// appear for one cycle with result_valid_o high and cannot be stalled.
module range_list_intersect
  import rli_pkg::*;
(
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [1:0]                    action_i,
  input  logic signed [BOUND_WIDTH-1:0] range_min_i,
  input  logic signed [BOUND_WIDTH-1:0] range_max_i,
  output logic                          result_valid_o,
  output logic signed [BOUND_WIDTH-1:0] overlap_low_o,
  output logic signed [BOUND_WIDTH-1:0] overlap_high_o,
  output logic                          last_of_run_o,
  output logic                          final_status_o,
  output logic                          no_overlap_o,
  output logic                          table_overflow_o
);

  state_e state_q, state_d;

  logic [CNT_W-1:0] count_q, count_d;
  logic [IDX_W-1:0] idx_q, idx_d;
  logic             rd_vld_q, rd_vld_d;
  logic             is_end_q, is_end_d;
  logic             pend_vld_q, pend_vld_d;
  logic signed [BOUND_WIDTH-1:0] pend_low_q, pend_low_d;
  logic signed [BOUND_WIDTH-1:0] pend_high_q, pend_high_d;
  logic signed [BOUND_WIDTH-1:0] new_low_q, new_low_d;
  logic signed [BOUND_WIDTH-1:0] new_high_q, new_high_d;
  logic             found_q, found_d;
  logic             ovf_q, ovf_d;
  logic             hold_vld_q, hold_vld_d;
  logic signed [BOUND_WIDTH-1:0] hold_low_q, hold_low_d;
  logic signed [BOUND_WIDTH-1:0] hold_high_q, hold_high_d;

  logic             out_vld_q, out_vld_d;
  logic signed [BOUND_WIDTH-1:0] out_low_q, out_low_d;
  logic signed [BOUND_WIDTH-1:0] out_high_q, out_high_d;
  logic             out_last_q, out_last_d;
  logic             out_fin_q, out_fin_d;
  logic             out_nov_q, out_nov_d;
  logic             out_ovf_q, out_ovf_d;

  logic             accept;
  action_e          act;
  logic             full;
  logic             extend;
  logic             flush_go;
  logic             last_idx;
  logic             ram_we;
  logic             ram_re;
  logic [ENTRY_W-1:0] ram_rdata;
  logic signed [BOUND_WIDTH-1:0] ent_min, ent_max;
  logic signed [BOUND_WIDTH-1:0] cmp_low, cmp_high;
  logic             cmp_hit;

  assign accept   = start_i && !busy_o;
  assign act      = action_e'(action_i);
  assign full     = (count_q == CNT_W'(TABLE_DEPTH));
  assign extend   = pend_vld_q && (range_min_i == pend_high_q);
  assign flush_go = pend_vld_q && (count_q != '0);
  assign last_idx = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);
  assign ram_we   = accept && (act == ACT_LOAD) && !full;
  assign ram_re   = (state_q == ST_SCAN);

  rli_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(count_q[IDX_W-1:0]),
    .wdata_i({range_min_i, range_max_i}),
    .re_i   (ram_re),
    .raddr_i(idx_q),
    .rdata_o(ram_rdata)
  );

  assign ent_min  = ram_rdata[ENTRY_W-1:BOUND_WIDTH];
  assign ent_max  = ram_rdata[BOUND_WIDTH-1:0];
  assign cmp_low  = (pend_low_q >= ent_min) ? pend_low_q : ent_min;
  assign cmp_high = (pend_high_q <= ent_max) ? pend_high_q : ent_max;
  assign cmp_hit  = rd_vld_q && (cmp_low <= cmp_high);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (act == ACT_FIRST && !extend && flush_go) begin
            state_d = ST_SCAN;
          end else if (act == ACT_END) begin
            state_d = flush_go ? ST_SCAN : ST_STATUS;
          end
        end
      end
      ST_SCAN: begin
        if (last_idx) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT:  state_d = ST_FLUSH;
      ST_FLUSH: state_d = is_end_q ? ST_STATUS : ST_IDLE;
      ST_STATUS: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    count_d     = count_q;
    idx_d       = idx_q;
    rd_vld_d    = (state_q == ST_SCAN);
    is_end_d    = is_end_q;
    pend_vld_d  = pend_vld_q;
    pend_low_d  = pend_low_q;
    pend_high_d = pend_high_q;
    new_low_d   = new_low_q;
    new_high_d  = new_high_q;
    found_d     = found_q;
    ovf_d       = ovf_q;
    hold_vld_d  = hold_vld_q;
    hold_low_d  = hold_low_q;
    hold_high_d = hold_high_q;
    out_vld_d   = 1'b0;
    out_low_d   = out_low_q;
    out_high_d  = out_high_q;
    out_last_d  = out_last_q;
    out_fin_d   = out_fin_q;
    out_nov_d   = out_nov_q;
    out_ovf_d   = out_ovf_q;

    if (cmp_hit) begin
      found_d     = 1'b1;
      hold_vld_d  = 1'b1;
      hold_low_d  = cmp_low;
      hold_high_d = cmp_high;
      if (hold_vld_q) begin
        out_vld_d  = 1'b1;
        out_low_d  = hold_low_q;
        out_high_d = hold_high_q;
        out_last_d = 1'b0;
        out_fin_d  = 1'b0;
        out_nov_d  = 1'b0;
        out_ovf_d  = 1'b0;
      end
    end

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (act)
            ACT_LOAD: begin
              if (full) begin
                ovf_d = 1'b1;
              end else begin
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_FIRST: begin
              if (extend) begin
                pend_high_d = range_max_i;
              end else if (flush_go) begin
                new_low_d  = range_min_i;
                new_high_d = range_max_i;
                is_end_d   = 1'b0;
                idx_d      = '0;
              end else begin
                pend_vld_d  = 1'b1;
                pend_low_d  = range_min_i;
                pend_high_d = range_max_i;
              end
            end
            ACT_END: begin
              is_end_d = 1'b1;
              idx_d    = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        idx_d = idx_q + IDX_W'(1);
      end
      ST_WAIT: begin
      end
      ST_FLUSH: begin
        if (hold_vld_q) begin
          out_vld_d  = 1'b1;
          out_low_d  = hold_low_q;
          out_high_d = hold_high_q;
          out_last_d = !is_end_q;
          out_fin_d  = 1'b0;
          out_nov_d  = 1'b0;
          out_ovf_d  = 1'b0;
        end
        hold_vld_d  = 1'b0;
        pend_vld_d  = !is_end_q;
        pend_low_d  = new_low_q;
        pend_high_d = new_high_q;
      end
      ST_STATUS: begin
        out_vld_d   = 1'b1;
        out_low_d   = '0;
        out_high_d  = '0;
        out_last_d  = 1'b1;
        out_fin_d   = 1'b1;
        out_nov_d   = !found_q;
        out_ovf_d   = ovf_q;
        count_d     = '0;
        pend_vld_d  = 1'b0;
        pend_low_d  = '0;
        pend_high_d = '0;
        found_d     = 1'b0;
        ovf_d       = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      is_end_q    <= 1'b0;
      pend_vld_q  <= 1'b0;
      pend_low_q  <= '0;
      pend_high_q <= '0;
      found_q     <= 1'b0;
      ovf_q       <= 1'b0;
      hold_vld_q  <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      rd_vld_q    <= rd_vld_d;
      is_end_q    <= is_end_d;
      pend_vld_q  <= pend_vld_d;
      pend_low_q  <= pend_low_d;
      pend_high_q <= pend_high_d;
      found_q     <= found_d;
      ovf_q       <= ovf_d;
      hold_vld_q  <= hold_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    new_low_q   <= new_low_d;
    new_high_q  <= new_high_d;
    hold_low_q  <= hold_low_d;
    hold_high_q <= hold_high_d;
    out_low_q   <= out_low_d;
    out_high_q  <= out_high_d;
    out_last_q  <= out_last_d;
    out_fin_q   <= out_fin_d;
    out_nov_q   <= out_nov_d;
    out_ovf_q   <= out_ovf_d;
  end

  assign busy_o           = (state_q != ST_IDLE);
  assign result_valid_o   = out_vld_q;
  assign overlap_low_o    = out_low_q;
  assign overlap_high_o   = out_high_q;
  assign last_of_run_o    = out_last_q;
  assign final_status_o   = out_fin_q;
  assign no_overlap_o     = out_nov_q;
  assign table_overflow_o = out_ovf_q;

  // The fill count never passes the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(TABLE_DEPTH))
    else $error("table count exceeds depth");

  // An accepted end request always sets the block busy in the following cycle.
  a_end_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && act == ACT_END) |=> busy_o)
    else $error("end request did not start a sequence");

  // The status result closes its run and the block is idle when it appears.
  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && final_status_o) |-> (last_of_run_o && !busy_o))
    else $error("status result not last or block still busy");

  // A held overlap is always given out before the block returns to idle.
  a_hold_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FLUSH) |=> !hold_vld_q)
    else $error("held overlap left after flush");

endmodule

### sim/range_list_intersect_test.sv
// Self-checking testbench for range_list_intersect with a class-based scoreboard and random list sets.
module range_list_intersect_test;
  import rli_pkg::*;

  typedef logic signed [BOUND_WIDTH-1:0] bound_t;

  localparam bound_t BOUND_LO = bound_t'(1 << (BOUND_WIDTH - 1));
  localparam bound_t BOUND_HI = ~BOUND_LO;
  localparam int ITEM_TARGET = 330;
  localparam int SETTLE_CYCLES = 2 * TABLE_DEPTH + 10;

  typedef struct {
    bound_t overlap_low;
    bound_t overlap_high;
    logic   last_of_run;
    logic   final_status;
    logic   no_overlap;
    logic   table_overflow;
  } overlap_t;

  class overlap_scoreboard;
    bound_t   table_min[TABLE_DEPTH];
    bound_t   table_max[TABLE_DEPTH];
    int       table_count;
    bit       run_valid;
    bound_t   run_low;
    bound_t   run_high;
    bit       found_any;
    bit       dropped_load;
    overlap_t expected_q[$];
    int       errors;

    function new();
      clear_lists();
      errors = 0;
    endfunction

    function void clear_lists();
      table_count = 0;
      run_valid = 1'b0;
      run_low = '0;
      run_high = '0;
      found_any = 1'b0;
      dropped_load = 1'b0;
    endfunction

    function void push_overlap(bound_t lo, bound_t hi, logic last, logic fin, logic nov,
                               logic ovf);
      overlap_t r;
      r.overlap_low = lo;
      r.overlap_high = hi;
      r.last_of_run = last;
      r.final_status = fin;
      r.no_overlap = nov;
      r.table_overflow = ovf;
      expected_q.push_back(r);
    endfunction

    // The pending range is compared with every stored range in table order.
    function int flush_run();
      bound_t lo;
      bound_t hi;
      int n;
      n = 0;
      if (run_valid) begin
        for (int j = 0; j < table_count; j++) begin
          lo = (run_low >= table_min[j]) ? run_low : table_min[j];
          hi = (run_high <= table_max[j]) ? run_high : table_max[j];
          if (lo <= hi) begin
            push_overlap(lo, hi, 1'b0, 1'b0, 1'b0, 1'b0);
            n++;
            found_any = 1'b1;
          end
        end
      end
      run_valid = 1'b0;
      return n;
    endfunction

    function void note_request(action_e act, bound_t lo, bound_t hi);
      int n;
      case (act)
        ACT_LOAD: begin
          if (table_count < TABLE_DEPTH) begin
            table_min[table_count] = lo;
            table_max[table_count] = hi;
            table_count++;
          end else begin
            dropped_load = 1'b1;
          end
        end
        ACT_FIRST: begin
          if (run_valid && lo == run_high) begin
            run_high = hi;
          end else begin
            n = flush_run();
            if (n > 0) begin
              expected_q[expected_q.size() - 1].last_of_run = 1'b1;
            end
            run_valid = 1'b1;
            run_low = lo;
            run_high = hi;
          end
        end
        ACT_END: begin
          void'(flush_run());
          push_overlap('0, '0, 1'b1, 1'b1, !found_any, dropped_load);
          clear_lists();
        end
        default: begin
        end
      endcase
    endfunction

    function void check_field(string name, logic signed [31:0] exp_v,
                              logic signed [31:0] got_v);
      if (got_v !== exp_v) begin
        $error("%s: expected %0d, got %0d", name, exp_v, got_v);
        errors++;
      end
    endfunction

    function void check_result(bound_t lo, bound_t hi, logic last, logic fin, logic nov,
                               logic ovf);
      overlap_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected result: overlap_low %0d, overlap_high %0d", lo, hi);
        errors++;
      end else begin
        e = expected_q.pop_front();
        check_field("overlap_low", e.overlap_low, lo);
        check_field("overlap_high", e.overlap_high, hi);
        check_field("last_of_run", e.last_of_run, last);
        check_field("final_status", e.final_status, fin);
        check_field("no_overlap", e.no_overlap, nov);
        check_field("table_overflow", e.table_overflow, ovf);
      end
    endfunction
  endclass

  logic   clk_i;
  logic   rst_ni;
  logic   start_i;
  logic   busy_o;
  logic [1:0] action_i;
  bound_t range_min_i;
  bound_t range_max_i;
  logic   result_valid_o;
  bound_t overlap_low_o;
  bound_t overlap_high_o;
  logic   last_of_run_o;
  logic   final_status_o;
  logic   no_overlap_o;
  logic   table_overflow_o;

  overlap_scoreboard sb = new();
  int request_count;
  int set_count;
  bit burst_mode;

  range_list_intersect uut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start_i),
    .busy_o           (busy_o),
    .action_i         (action_i),
    .range_min_i      (range_min_i),
    .range_max_i      (range_max_i),
    .result_valid_o   (result_valid_o),
    .overlap_low_o    (overlap_low_o),
    .overlap_high_o   (overlap_high_o),
    .last_of_run_o    (last_of_run_o),
    .final_status_o   (final_status_o),
    .no_overlap_o     (no_overlap_o),
    .table_overflow_o (table_overflow_o)
  );

  initial begin
    clk_i = 1'b0;
  end

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      sb.check_result(overlap_low_o, overlap_high_o, last_of_run_o, final_status_o,
                      no_overlap_o, table_overflow_o);
    end
  end

  function automatic bound_t clamp_bound(int v);
    if (v < int'(BOUND_LO)) begin
      return BOUND_LO;
    end
    if (v > int'(BOUND_HI)) begin
      return BOUND_HI;
    end
    return bound_t'(v);
  endfunction

  // Most ranges cluster around the base of the set so that overlaps are common.
  function automatic void pick_range(int base, output bound_t lo, output bound_t hi);
    int r;
    int a;
    r = $urandom_range(0, 19);
    a = base + int'($urandom_range(0, 400)) - 200;
    if (r == 0) begin
      lo = bound_t'($urandom);
      hi = bound_t'($urandom);
    end else if (r == 1) begin
      lo = clamp_bound(a);
      hi = clamp_bound(a - int'($urandom_range(1, 100)));
    end else begin
      lo = clamp_bound(a);
      hi = clamp_bound(a + int'($urandom_range(0, 150)));
    end
  endfunction

  task automatic send_request(action_e act, bound_t lo, bound_t hi);
    @(negedge clk_i);
    start_i = 1'b1;
    action_i = act;
    range_min_i = lo;
    range_max_i = hi;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_request(act, lo, hi);
    if (act != ACT_NONE) begin
      request_count++;
    end
  endtask

  task automatic idle_gap();
    int n;
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) begin
      n = 0;
    end else if (r < 85) begin
      n = $urandom_range(1, 3);
    end else if (r < 97) begin
      n = $urandom_range(4, 10);
    end else begin
      n = $urandom_range(20, 60);
    end
    repeat (n) begin
      @(negedge clk_i);
      start_i = 1'b0;
      action_i = 2'($urandom);
      range_min_i = bound_t'($urandom);
      range_max_i = bound_t'($urandom);
    end
  endtask

  task automatic wait_drained();
    int spins;
    spins = 0;
    @(negedge clk_i);
    start_i = 1'b0;
    while (sb.expected_q.size() > 0 && spins < 20000) begin
      @(posedge clk_i);
      spins++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic run_list_set();
    int base;
    int loads;
    int firsts;
    int r;
    bit chained;
    bound_t lo;
    bound_t hi;
    bound_t prev_max;
    base = int'($urandom_range(0, 65535)) - 32768;
    burst_mode = ($urandom_range(0, 5) == 0);
    chained = 1'b0;
    prev_max = '0;
    r = $urandom_range(0, 9);
    if (r == 0) begin
      loads = 0;
    end else if (r < 8) begin
      loads = $urandom_range(1, 6);
    end else if (r == 8) begin
      loads = $urandom_range(7, 16);
    end else begin
      loads = $urandom_range(TABLE_DEPTH, TABLE_DEPTH + 4);
    end
    for (int i = 0; i < loads; i++) begin
      pick_range(base, lo, hi);
      send_request(ACT_LOAD, lo, hi);
      idle_gap();
    end
    firsts = $urandom_range(0, 8);
    for (int i = 0; i < firsts; i++) begin
      r = $urandom_range(0, 19);
      if (r == 0) begin
        send_request(ACT_NONE, bound_t'($urandom), bound_t'($urandom));
        idle_gap();
      end else if (r == 1) begin
        pick_range(base, lo, hi);
        send_request(ACT_LOAD, lo, hi);
        idle_gap();
      end
      if (chained && $urandom_range(0, 2) == 0) begin
        lo = prev_max;
        hi = clamp_bound(int'(prev_max) + int'($urandom_range(0, 120)));
      end else begin
        pick_range(base, lo, hi);
      end
      send_request(ACT_FIRST, lo, hi);
      prev_max = hi;
      chained = 1'b1;
      idle_gap();
    end
    send_request(ACT_END, bound_t'($urandom), bound_t'($urandom));
    idle_gap();
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    action_i = ACT_NONE;
    range_min_i = '0;
    range_max_i = '0;
    request_count = 0;
    set_count = 0;
    burst_mode = 1'b1;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_request(ACT_END, 0, 0);
    send_request(ACT_FIRST, -5, 5);
    send_request(ACT_END, 0, 0);
    send_request(ACT_LOAD, BOUND_LO, BOUND_HI);
    send_request(ACT_LOAD, 0, 0);
    send_request(ACT_LOAD, 10, -10);
    send_request(ACT_LOAD, 100, 200);
    send_request(ACT_FIRST, BOUND_LO, -1);
    send_request(ACT_FIRST, -1, 50);
    send_request(ACT_NONE, BOUND_HI, BOUND_LO);
    send_request(ACT_FIRST, BOUND_HI, BOUND_HI);
    burst_mode = 1'b0;
    idle_gap();
    send_request(ACT_FIRST, 5, -5);
    idle_gap();
    send_request(ACT_LOAD, -5, 5);
    send_request(ACT_FIRST, -3, 150);
    send_request(ACT_END, BOUND_HI, BOUND_LO);
    send_request(ACT_FIRST, BOUND_HI, BOUND_LO);
    send_request(ACT_END, -1, -1);
    wait_drained();

    while (request_count < ITEM_TARGET) begin
      run_list_set();
      set_count++;
      if (set_count % 8 == 0) begin
        wait_drained();
      end
    end
    wait_drained();

    if (sb.expected_q.size() > 0) begin
      $error("%0d expected results never arrived", sb.expected_q.size());
      sb.errors++;
    end
    if (sb.errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

### range_list_intersect.f
rtl/rli_pkg.sv
rtl/rli_ram.sv
rtl/range_list_intersect.sv
sim/range_list_intersect_test.sv
